>>> rtl/core/frame_crc16_kermit_tail_macros.svh
// Assertion macros for the frame_crc16_kermit_tail checker.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef FRAME_CRC16_KERMIT_TAIL_MACROS_SVH
`define FRAME_CRC16_KERMIT_TAIL_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FCRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define FCRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/fcrc_pkg.sv
// Shared types, constants and the byte-wide CRC-16/Kermit update.
// Used by every module of frame_crc16_kermit_tail; no dependencies.
`timescale 1ns / 1ps

package fcrc_pkg;

  localparam logic [15:0] CRC_POLY   = 16'h8408;
  localparam logic [15:0] CRC_INIT   = 16'h0000;
  localparam int          QUEUE_DEPTH = 2;

  // Work unit handed from the front to the back: one to three output bytes.
  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] last_idx;    // index of the final byte in this unit
    logic       frame_done;  // final byte of the unit closes the frame
    logic       crc_ok;
    logic       too_short;
  } fcrc_desc_t;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc_byte(logic [15:0] acc, logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> rtl/core/fcrc_queue.sv
// Small register queue of work units between front and back.
// Depends on fcrc_pkg for the work unit type.
`timescale 1ns / 1ps

module fcrc_queue #(
  parameter int DEPTH = fcrc_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  fcrc_pkg::fcrc_desc_t push_desc,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output fcrc_pkg::fcrc_desc_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fcrc_pkg::fcrc_desc_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/core/fcrc_front.sv
// Front end: accepts frame bytes, keeps the CRC and the two-byte tail delay,
// and turns the bytes it releases into work units. Depends on fcrc_pkg.
`timescale 1ns / 1ps

module fcrc_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic                 cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 frame_end,
  input  logic                 q_full,
  output logic                 push,
  output fcrc_pkg::fcrc_desc_t push_desc
);

  logic        check_mode;
  logic [15:0] crc;
  logic [7:0]  hold0;
  logic [7:0]  hold1;
  logic [1:0]  bytes_seen;
  logic        accept;
  logic [15:0] crc_fold;
  logic        tail_ok;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign crc_fold = fcrc_pkg::crc_byte(crc, hold0);
  assign tail_ok  = (hold1 == crc_fold[7:0]) && (data_byte == crc_fold[15:8]);

  always_comb begin
    push_desc = '0;
    push      = 1'b0;
    if (!frame_end) begin
      // release the older held byte once two are in the delay line
      push         = accept && (bytes_seen >= 2'd2);
      push_desc.b0 = hold0;
    end else begin
      push                 = accept;
      push_desc.frame_done = 1'b1;
      if (bytes_seen >= 2'd2) begin
        push_desc.b0       = hold0;
        push_desc.last_idx = 2'd2;
        if (check_mode) begin
          push_desc.b1     = hold1;
          push_desc.b2     = data_byte;
          push_desc.crc_ok = tail_ok;
        end else begin
          push_desc.b1 = crc_fold[7:0];
          push_desc.b2 = crc_fold[15:8];
        end
      end else begin
        push_desc.too_short = 1'b1;
        if (bytes_seen == 2'd1) begin
          push_desc.b0       = hold0;
          push_desc.b1       = data_byte;
          push_desc.last_idx = 2'd1;
        end else begin
          push_desc.b0 = data_byte;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_mode <= 1'b0;
      crc        <= fcrc_pkg::CRC_INIT;
      hold0      <= '0;
      hold1      <= '0;
      bytes_seen <= '0;
    end else begin
      if (cfg_we) begin
        check_mode <= cfg_wdata;
      end
      if (accept) begin
        if (frame_end) begin
          crc        <= fcrc_pkg::CRC_INIT;
          hold0      <= '0;
          hold1      <= '0;
          bytes_seen <= '0;
        end else begin
          if (bytes_seen >= 2'd2) begin
            crc   <= crc_fold;
            hold0 <= hold1;
            hold1 <= data_byte;
          end else if (bytes_seen[0]) begin
            hold1 <= data_byte;
          end else begin
            hold0 <= data_byte;
          end
          if (bytes_seen != 2'd3) begin
            bytes_seen <= bytes_seen + 1'b1;
          end
        end
      end
    end
  end

endmodule

>>> rtl/core/fcrc_back.sv
// Back end: walks each work unit byte by byte into the output register.
// Depends on fcrc_pkg.
`timescale 1ns / 1ps

module fcrc_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 head_valid,
  input  fcrc_pkg::fcrc_desc_t head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [7:0]           out_byte,
  output logic                 out_last,
  output logic                 crc_ok,
  output logic                 too_short
);

  logic [1:0] idx;
  logic       emit;
  logic       unit_end;
  logic       is_last;
  logic [7:0] sel_byte;

  assign emit     = head_valid && (!out_valid || out_ready);
  assign unit_end = (idx == head.last_idx);
  assign is_last  = unit_end && head.frame_done;
  assign pop      = emit && unit_end;

  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.b0;
      2'd1:    sel_byte = head.b1;
      default: sel_byte = head.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        idx       <= unit_end ? 2'd0 : idx + 1'b1;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte  <= sel_byte;
      out_last  <= is_last;
      crc_ok    <= is_last && head.crc_ok;
      too_short <= is_last && head.too_short;
    end
  end

endmodule

>>> rtl/core/frame_crc16_kermit_tail.sv
// CRC-16/Kermit frame tail generator and checker.
// Input channel: in_valid/in_ready carry data_byte and frame_end (last byte of a frame).
// Output channel: out_valid/out_ready carry out_byte, out_last, crc_ok, too_short.
// cfg_we/cfg_wdata write check_mode (0 generate, 1 check); write only while idle.
// The CRC covers every byte but the last two, which sit in a two-byte delay line.
// Generate mode swaps those two bytes for the CRC, low byte first; check mode
// passes them and raises crc_ok on the last byte if they match the CRC.
// Frames of one or two bytes pass unchanged with too_short set on the last byte.
// Throughput: one byte per cycle while the queue has room; the back end emits
// the bytes of each unit one at a time, so a frame's three-byte flush keeps it
// busy, and short frames that follow can fill the two-entry queue and drop in_ready.
// Each output is written first into a queue entry, then into the output register.
// in_ready drops only while the queue between front and back is full.
// Stalls on out_ready hold the output register and back up through the queue.
// Synchronous reset clears the CRC, the delay line, check_mode and both channels.
`timescale 1ns / 1ps

module frame_crc16_kermit_tail #(
  parameter int QUEUE_DEPTH = fcrc_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       frame_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       crc_ok,
  output logic       too_short
);

  logic                 q_full;
  logic                 push;
  fcrc_pkg::fcrc_desc_t push_desc;
  logic                 pop;
  logic                 head_valid;
  fcrc_pkg::fcrc_desc_t head;

  fcrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .frame_end (frame_end),
    .q_full    (q_full),
    .push      (push),
    .push_desc (push_desc)
  );

  fcrc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_desc  (push_desc),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  fcrc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .crc_ok     (crc_ok),
    .too_short  (too_short)
  );

endmodule

>>> rtl/core/fcrc_checker.sv
// Port-level checker for frame_crc16_kermit_tail, bound to the top level.
// Depends on frame_crc16_kermit_tail_macros.svh.
`timescale 1ns / 1ps
`include "frame_crc16_kermit_tail_macros.svh"

module fcrc_checker (
  input logic       clk,
  input logic       rst,
  input logic       cfg_we,
  input logic       cfg_wdata,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] data_byte,
  input logic       frame_end,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic       crc_ok,
  input logic       too_short
);

  // a stalled output transaction keeps its payload
  `FCRC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last) && $stable(crc_ok) && $stable(too_short), "output changed while stalled")

  `FCRC_ASSERT_NOW(a_flags_on_last, out_valid && !out_last, !crc_ok && !too_short, "status flag set before the frame's last byte")

  `FCRC_ASSERT_NOW(a_flags_exclusive, out_valid, !(crc_ok && too_short), "short frame reported as matching CRC")

  `FCRC_ASSERT_NOW(a_reset_idle, $past(rst), !out_valid, "output valid right after reset")

endmodule

bind frame_crc16_kermit_tail fcrc_checker u_fcrc_checker (.*);

>>> tb/frame_crc16_kermit_tail_checker.sv
// Checker for frame_crc16_kermit_tail: watches the config port and both channels,
// predicts every output transaction and compares it field by field.
// Depends on nothing but the signals it is wired to.
`timescale 1ns / 1ps

module frame_crc16_kermit_tail_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       frame_end,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  input  logic       crc_ok,
  input  logic       too_short,
  output int         fail_count,
  output int         pending
);

  localparam logic [15:0] KERMIT_POLY = 16'h8408;

  typedef struct packed {
    logic [7:0] val;
    logic       last;
    logic       ok;
    logic       shrt;
  } frame_out_t;

  frame_out_t  due_q[$];
  frame_out_t  got;
  frame_out_t  want;
  logic        check_on = 1'b0;
  logic [15:0] crc_acc = '0;
  logic [7:0]  hold0 = '0;
  logic [7:0]  hold1 = '0;
  logic [1:0]  seen = '0;
  int          errs = 0;

  function automatic logic [15:0] kermit_step(logic [15:0] acc, logic [7:0] b);
    logic [15:0] c;
    c = acc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ KERMIT_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic emit(logic [7:0] val, logic last, logic ok, logic shrt);
    due_q.push_back({val, last, ok, shrt});
  endtask

  // Advance the framer by one accepted byte and queue what it releases.
  task automatic take_byte(logic [7:0] b, logic e);
    logic [15:0] crc;
    if (!e) begin
      if (seen >= 2) begin
        emit(hold0, 1'b0, 1'b0, 1'b0);
        crc_acc = kermit_step(crc_acc, hold0);
        hold0 = hold1;
        hold1 = b;
      end else if (seen == 0) begin
        hold0 = b;
      end else begin
        hold1 = b;
      end
      if (seen != 2'd3) seen = seen + 2'd1;
    end else begin
      if (seen >= 2) begin
        emit(hold0, 1'b0, 1'b0, 1'b0);
        crc = kermit_step(crc_acc, hold0);
        if (check_on) begin
          emit(hold1, 1'b0, 1'b0, 1'b0);
          emit(b, 1'b1, (hold1 == crc[7:0]) && (b == crc[15:8]), 1'b0);
        end else begin
          emit(crc[7:0], 1'b0, 1'b0, 1'b0);
          emit(crc[15:8], 1'b1, 1'b0, 1'b0);
        end
      end else begin
        if (seen == 1) emit(hold0, 1'b0, 1'b0, 1'b0);
        emit(b, 1'b1, 1'b0, 1'b1);
      end
      crc_acc = '0;
      hold0 = '0;
      hold1 = '0;
      seen = '0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      due_q.delete();
      check_on = 1'b0;
      crc_acc = '0;
      hold0 = '0;
      hold1 = '0;
      seen = '0;
    end else begin
      if (cfg_we) check_on = cfg_wdata;
      // Pop before push: an output never belongs to a byte taken at the same edge.
      if (out_valid && out_ready) begin
        got = {out_byte, out_last, crc_ok, too_short};
        if (due_q.size() == 0) begin
          $error("unexpected output transaction: out_byte %0h", out_byte);
          errs = errs + 1;
        end else begin
          want = due_q.pop_front();
          if (got.val !== want.val) begin
            $error("out_byte: expected %0h, got %0h", want.val, got.val);
            errs = errs + 1;
          end
          if (got.last !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, got.last);
            errs = errs + 1;
          end
          if (got.ok !== want.ok) begin
            $error("crc_ok: expected %0b, got %0b", want.ok, got.ok);
            errs = errs + 1;
          end
          if (got.shrt !== want.shrt) begin
            $error("too_short: expected %0b, got %0b", want.shrt, got.shrt);
            errs = errs + 1;
          end
        end
      end
      if (in_valid && in_ready) take_byte(data_byte, frame_end);
    end
    fail_count <= errs;
    pending <= due_q.size();
  end

endmodule

>>> tb/frame_crc16_kermit_tail_tb.sv
// Top of the frame_crc16_kermit_tail testbench: clock, reset, frame stimulus,
// random stalls on both channels and the verdict.
// Depends on the block's RTL and on frame_crc16_kermit_tail_checker.
`timescale 1ns / 1ps

module frame_crc16_kermit_tail_tb;

  localparam logic MODE_GEN   = 1'b0;
  localparam logic MODE_CHECK = 1'b1;
  localparam int   ITEM_GOAL  = 300;
  localparam int   QUIET_FROM = 250;
  localparam int   CYCLE_LIMIT = 200000;
  localparam logic [15:0] KERMIT_POLY = 16'h8408;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] data_byte = 8'h00;
  logic       frame_end = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       crc_ok;
  logic       too_short;
  int         fail_count;
  int         pending;

  logic       quiet = 1'b0;
  int         ready_left = 0;
  int         cycle_count = 0;
  int         sent = 0;
  logic [7:0] frame_q[$];

  frame_crc16_kermit_tail uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .frame_end (frame_end),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .crc_ok    (crc_ok),
    .too_short (too_short)
  );

  frame_crc16_kermit_tail_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .frame_end  (frame_end),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .out_last   (out_last),
    .crc_ok     (crc_ok),
    .too_short  (too_short),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: alternate random stall and run bursts; always ready once quiet.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      ready_left <= 0;
    end else if (quiet) begin
      out_ready <= 1'b1;
    end else if (ready_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        ready_left <= $urandom_range(0, 14);
      end else begin
        out_ready <= 1'b1;
        ready_left <= $urandom_range(0, 39);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // Append a correct CRC-16/Kermit tail, low byte first, over the bytes in frame_q.
  task automatic seal_frame();
    logic [15:0] acc;
    logic        fb;
    acc = 16'h0000;
    foreach (frame_q[i]) begin
      for (int k = 0; k < 8; k++) begin
        fb = acc[0] ^ frame_q[i][k];
        acc = acc >> 1;
        if (fb) acc = acc ^ KERMIT_POLY;
      end
    end
    frame_q.push_back(acc[7:0]);
    frame_q.push_back(acc[15:8]);
  endtask

  task automatic send_item(logic [7:0] b, logic e);
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    frame_end <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent = sent + 1;
  endtask

  task automatic send_frame();
    foreach (frame_q[i]) send_item(frame_q[i], i == frame_q.size() - 1);
  endtask

  // Wait for the block to drain, then write check_mode.
  task automatic set_mode(logic mode);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic build_random_frame();
    int r;
    int len;
    int fill;
    r = $urandom_range(0, 19);
    if (r < 3) len = $urandom_range(1, 2);
    else if (r < 17) len = $urandom_range(3, 8);
    else len = $urandom_range(9, 24);
    fill = $urandom_range(0, 9);
    frame_q.delete();
    if (len <= 2) begin
      repeat (len) frame_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat (len - 2) begin
      if (fill == 0) frame_q.push_back(8'h00);
      else if (fill == 1) frame_q.push_back(8'hFF);
      else frame_q.push_back(8'($urandom_range(0, 255)));
    end
    r = $urandom_range(0, 7);
    if (r < 6) begin
      seal_frame();
    end else if (r == 6) begin
      // corrupt one bit of an otherwise good tail
      seal_frame();
      frame_q[frame_q.size() - 1 - $urandom_range(0, 1)] ^= 8'(1 << $urandom_range(0, 7));
    end else begin
      frame_q.push_back(8'($urandom_range(0, 255)));
      frame_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Generate mode: short frames, all-ones frame, mixed extremes.
    set_mode(MODE_GEN);
    frame_q = '{8'hFF};
    send_frame();
    frame_q = '{8'h00, 8'hFF};
    send_frame();
    frame_q = '{8'hFF, 8'hFF, 8'hFF};
    send_frame();
    frame_q = '{8'h00, 8'h80, 8'h01, 8'h7F};
    send_frame();

    // Check mode: short frames, good tails, a zero CRC and a corrupted tail.
    set_mode(MODE_CHECK);
    frame_q = '{8'h00};
    send_frame();
    frame_q = '{8'hA5, 8'h5A};
    send_frame();
    frame_q = '{8'hFF};
    seal_frame();
    send_frame();
    frame_q = '{8'h12, 8'h34};
    seal_frame();
    frame_q[3] ^= 8'h80;
    send_frame();
    frame_q = '{8'h00, 8'h00, 8'h00};
    seal_frame();
    send_frame();

    while (sent < ITEM_GOAL) begin
      // mode changes drain the block, so keep them out of the quiet tail
      if (sent < QUIET_FROM && $urandom_range(0, 5) == 0) set_mode(1'($urandom_range(0, 1)));
      if (sent >= QUIET_FROM) quiet <= 1'b1;
      build_random_frame();
      send_frame();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/fcrc_pkg.sv
rtl/core/fcrc_queue.sv
rtl/core/fcrc_front.sv
rtl/core/fcrc_back.sv
rtl/core/frame_crc16_kermit_tail.sv
rtl/core/fcrc_checker.sv
tb/frame_crc16_kermit_tail_checker.sv
tb/frame_crc16_kermit_tail_tb.sv
